// ===== hw/rtl/bouncing_ball_led_span_macros.svh =====
// Assertion macros shared by the bouncing ball block
`ifndef BOUNCING_BALL_LED_SPAN_MACROS_SVH
`define BOUNCING_BALL_LED_SPAN_MACROS_SVH

`ifndef SYNTHESIS
`define BBLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BBLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BBLS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBLS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/bbls_pkg.sv =====
`timescale 1ns / 1ps

package bbls_pkg;

  localparam int POS_W     = 24;
  localparam int FRAC_W    = 12;
  localparam int INT_W     = POS_W - FRAC_W;
  localparam int IDX_W     = 10;
  localparam int HUE_W     = 16;
  localparam int BRT_W     = 8;
  localparam int FT_W      = 9;
  localparam int DT_W      = 16;
  localparam int SPD_W     = 23;
  localparam int BF_W      = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = POS_W + MUL_B_W;
  localparam int SUM_W     = 27;
  localparam int QUO_W     = 9;
  localparam int DIV_W     = POS_W + QUO_W - 1;
  localparam int REM_W     = 25;
  localparam int DIV_CNT_W = 4;

  localparam int FT_MIN  = 200;
  localparam int FT_NUM  = 20480000;
  localparam int V_OFS   = 40960;
  localparam int BF_MIN  = 327;
  localparam int V_MIN   = 40;
  localparam int Q24_MAX = 8388607;
  localparam int Q24_MIN = -8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION,
    CFG_START_POS,
    CFG_START_SPEED,
    CFG_START_HUE,
    CFG_HUE_SHIFT,
    CFG_GRAVITY,
    CFG_BOUNCE,
    CFG_BRIGHTNESS
  } cfg_idx_t;

  typedef enum logic {
    KIND_LAUNCH = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  typedef struct packed {
    logic load_dt;
    logic launch;
    logic mul_pos;
    logic upd_pos;
    logic mul_vel;
    logic upd_vel;
    logic check;
    logic bounce;
    logic div_step;
    logic emit_light;
    logic emit_status;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic same_idx;
    logic div_done;
    logic span_last;
    logic out_free;
  } sts_t;

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [SUM_W-1:0] x);
    if (x > SUM_W'(Q24_MAX)) begin
      return POS_W'(Q24_MAX);
    end else if (x < SUM_W'(Q24_MIN)) begin
      return POS_W'(Q24_MIN);
    end else begin
      return x[POS_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/bbls_in_if.sv =====
`timescale 1ns / 1ps

interface bbls_in_if import bbls_pkg::*;;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [DT_W-1:0]  elapsed_time;

  modport source (output valid, kind, elapsed_time, input ready);
  modport sink   (input valid, kind, elapsed_time, output ready);
endinterface

// ===== hw/rtl/bbls_out_if.sv =====
`timescale 1ns / 1ps

interface bbls_out_if import bbls_pkg::*;;
  logic             valid;
  logic             ready;
  logic             light_valid;
  logic [IDX_W-1:0] led_index;
  logic [HUE_W-1:0] light_hue;
  logic [BRT_W-1:0] light_brightness;
  logic [FT_W-1:0]  fall_time_ms;
  logic             finished;
  logic             last;

  modport source (output valid, light_valid, led_index, light_hue, light_brightness,
                  fall_time_ms, finished, last, input ready);
  modport sink   (input valid, light_valid, led_index, light_hue, light_brightness,
                  fall_time_ms, finished, last, output ready);
endinterface

// ===== hw/rtl/bbls_datapath.sv =====
`timescale 1ns / 1ps
`include "bouncing_ball_led_span_macros.svh"

module bbls_datapath import bbls_pkg::*; #(
  parameter int LED_COUNT = 1024,
  parameter int MAX_SPAN = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [DT_W-1:0]      in_elapsed_time,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  bbls_out_if.source           out_ch
);

  localparam int CNT_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam logic signed [POS_W-1:0] END_POS = POS_W'((LED_COUNT - 1) * (2 ** FRAC_W));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [IDX_W-1:0] SPAN_CAP = IDX_W'(MAX_SPAN - 1);

  logic                     dir_cfg_r;
  logic [IDX_W-1:0]         start_pos_r;
  logic [SPD_W-1:0]         start_speed_r;
  logic [HUE_W-1:0]         start_hue_r;
  logic [HUE_W-1:0]         hue_shift_cfg_r;
  logic signed [POS_W-1:0]  gravity_r;
  logic [BF_W-1:0]          bf_r;
  logic [BRT_W-1:0]         bright_cfg_r;

  logic signed [POS_W-1:0]  pos_r;
  logic signed [POS_W-1:0]  vel_r;
  logic signed [POS_W-1:0]  egrav_r;
  logic [HUE_W-1:0]         hue_acc_r;
  logic                     fin_r;
  logic                     run_dir_r;
  logic [HUE_W-1:0]         run_shift_r;
  logic [BRT_W-1:0]         run_bright_r;

  logic [DT_W-1:0]          dt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [IDX_W-1:0]         prev_idx_r;
  logic [IDX_W-1:0]         new_idx_r;
  logic [POS_W-1:0]         absv_r;
  logic                     hit_r;
  logic [IDX_W-1:0]         idx_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [REM_W-1:0]         rem_r;
  logic [DIV_W-1:0]         dvs_sh_r;
  logic [QUO_W-1:0]         q_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;

  logic                     out_valid_r;
  logic                     light_valid_r;
  logic [IDX_W-1:0]         led_index_r;
  logic [HUE_W-1:0]         light_hue_r;
  logic [BRT_W-1:0]         light_bright_r;
  logic [FT_W-1:0]          fall_time_r;
  logic                     finished_r;
  logic                     last_r;

  logic signed [POS_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [SUM_W-1:0]   pos_sum;
  logic signed [SUM_W-1:0]   vel_sum;
  logic signed [SUM_W-1:0]   bnc_neg;
  logic signed [POS_W-1:0]   launch_vel;
  logic signed [POS_W-1:0]   launch_grav;
  logic [IDX_W-1:0]          span_lo;
  logic [IDX_W-1:0]          span_diff;
  logic [IDX_W-1:0]          span_clip;
  logic [DIV_W-1:0]          rem_ext;
  logic [POS_W-1:0]          dvs;
  logic [FT_W-1:0]           fall_time;
  logic [HUE_W-1:0]          hue_nxt;
  logic                      out_free;

  function automatic logic [IDX_W-1:0] index_of(input logic signed [POS_W-1:0] p);
    logic [INT_W-1:0] whole;
    whole = p[POS_W-1:FRAC_W];
    if (p[POS_W-1]) begin
      return '0;
    end else if (whole > INT_W'(LED_COUNT - 1)) begin
      return LAST_IDX;
    end else begin
      return whole[IDX_W-1:0];
    end
  endfunction

  always_comb begin
    mul_a = vel_r;
    mul_b = {1'b0, dt_r};
    if (cmd.mul_vel) begin
      mul_a = egrav_r;
    end
    if (cmd.check) begin
      mul_b = {1'b0, bf_r};
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign pos_sum = SUM_W'(pos_r) + SUM_W'($signed(prod_r[PROD_W-1:16]));
  assign vel_sum = SUM_W'(vel_r) + SUM_W'($signed(prod_r[PROD_W-1:16]));
  assign bnc_neg = -SUM_W'($signed(prod_r[PROD_W-1:15]));

  assign launch_vel  = dir_cfg_r ? POS_W'({1'b0, start_speed_r})
                                 : -POS_W'({1'b0, start_speed_r});
  assign launch_grav = (dir_cfg_r || gravity_r[POS_W-1]) ? gravity_r : -gravity_r;

  assign span_lo   = (prev_idx_r < new_idx_r) ? prev_idx_r : new_idx_r;
  assign span_diff = (prev_idx_r < new_idx_r) ? (new_idx_r - prev_idx_r)
                                              : (prev_idx_r - new_idx_r);
  assign span_clip = (span_diff > SPAN_CAP) ? SPAN_CAP : span_diff;

  assign dvs       = absv_r + POS_W'(V_OFS);
  assign rem_ext   = DIV_W'(rem_r);
  assign fall_time = (q_r < QUO_W'(FT_MIN)) ? FT_W'(FT_MIN) : q_r;
  assign hue_nxt   = hue_acc_r + run_shift_r;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign sts.finished  = fin_r;
  assign sts.same_idx  = (new_idx_r == prev_idx_r);
  assign sts.div_done  = (div_cnt_r == '0);
  assign sts.span_last = (cnt_r == '0);
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_cfg_r       <= 1'b1;
      start_pos_r     <= '0;
      start_speed_r   <= '0;
      start_hue_r     <= '0;
      hue_shift_cfg_r <= '0;
      gravity_r       <= '0;
      bf_r            <= BF_W'(26214);
      bright_cfg_r    <= '1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIRECTION:   dir_cfg_r       <= cfg_data[0];
        CFG_START_POS:   start_pos_r     <= cfg_data[IDX_W-1:0];
        CFG_START_SPEED: start_speed_r   <= cfg_data[SPD_W-1:0];
        CFG_START_HUE:   start_hue_r     <= cfg_data[HUE_W-1:0];
        CFG_HUE_SHIFT:   hue_shift_cfg_r <= cfg_data[HUE_W-1:0];
        CFG_GRAVITY:     gravity_r       <= $signed(cfg_data[POS_W-1:0]);
        CFG_BOUNCE:      bf_r            <= cfg_data[BF_W-1:0];
        CFG_BRIGHTNESS:  bright_cfg_r    <= cfg_data[BRT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      vel_r        <= '0;
      egrav_r      <= '0;
      hue_acc_r    <= '0;
      fin_r        <= 1'b1;
      run_dir_r    <= 1'b1;
      run_shift_r  <= '0;
      run_bright_r <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.launch) begin
        pos_r        <= {{(INT_W - IDX_W){1'b0}}, start_pos_r, {FRAC_W{1'b0}}};
        vel_r        <= launch_vel;
        egrav_r      <= launch_grav;
        hue_acc_r    <= start_hue_r;
        fin_r        <= 1'b0;
        run_dir_r    <= dir_cfg_r;
        run_shift_r  <= hue_shift_cfg_r;
        run_bright_r <= bright_cfg_r;
      end
      if (cmd.upd_pos) begin
        pos_r <= sat24(pos_sum);
      end
      if (cmd.upd_vel) begin
        vel_r <= sat24(vel_sum);
      end
      if (cmd.bounce && hit_r) begin
        vel_r <= sat24(bnc_neg);
        pos_r <= run_dir_r ? END_POS : '0;
        if ((bf_r <= BF_W'(BF_MIN)) || (absv_r <= POS_W'(V_MIN))) begin
          fin_r <= 1'b1;
        end
      end
      if (cmd.emit_light) begin
        hue_acc_r <= hue_nxt;
      end
      if (cmd.emit_light || cmd.emit_status) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_dt) begin
      dt_r <= in_elapsed_time;
    end
    if (cmd.mul_pos || cmd.mul_vel || cmd.check) begin
      prod_r <= mul_p;
    end
    if (cmd.upd_pos) begin
      prev_idx_r <= index_of(pos_r);
    end
    if (cmd.check) begin
      new_idx_r <= index_of(pos_r);
      absv_r    <= vel_r[POS_W-1] ? (~vel_r + POS_W'(1)) : vel_r;
      hit_r     <= run_dir_r ? (pos_r >= END_POS) : (pos_r <= 0);
    end
    if (cmd.bounce) begin
      idx_r     <= span_lo;
      cnt_r     <= span_clip[CNT_W-1:0];
      rem_r     <= REM_W'(FT_NUM);
      dvs_sh_r  <= {dvs, {(QUO_W - 1){1'b0}}};
      q_r       <= '0;
      div_cnt_r <= DIV_CNT_W'(QUO_W - 1);
    end
    if (cmd.div_step) begin
      if (rem_ext >= dvs_sh_r) begin
        rem_r <= rem_r - dvs_sh_r[REM_W-1:0];
        q_r   <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QUO_W-2:0], 1'b0};
      end
      dvs_sh_r  <= dvs_sh_r >> 1;
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end
    if (cmd.emit_light) begin
      idx_r          <= idx_r + IDX_W'(1);
      cnt_r          <= cnt_r - CNT_W'(1);
      light_valid_r  <= 1'b1;
      led_index_r    <= idx_r;
      light_hue_r    <= hue_nxt;
      light_bright_r <= run_bright_r;
      fall_time_r    <= fall_time;
      finished_r     <= fin_r;
      last_r         <= (cnt_r == '0);
    end else if (cmd.emit_status) begin
      light_valid_r  <= 1'b0;
      led_index_r    <= '0;
      light_hue_r    <= '0;
      light_bright_r <= '0;
      fall_time_r    <= '0;
      finished_r     <= fin_r;
      last_r         <= 1'b1;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.light_valid      = light_valid_r;
  assign out_ch.led_index        = led_index_r;
  assign out_ch.light_hue        = light_hue_r;
  assign out_ch.light_brightness = light_bright_r;
  assign out_ch.fall_time_ms     = fall_time_r;
  assign out_ch.finished         = finished_r;
  assign out_ch.last             = last_r;

  `BBLS_ASSERT_IMP(a_fall_range, clk, rst_n, cmd.emit_light, (fall_time >= FT_W'(FT_MIN)) && (fall_time <= FT_W'(500)))
  `BBLS_ASSERT_IMP(a_idx_on_strip, clk, rst_n, cmd.emit_light, idx_r <= LAST_IDX)
  `BBLS_ASSERT_NXT(a_bounce_end, clk, rst_n, cmd.bounce && hit_r && run_dir_r, pos_r == END_POS)

endmodule

// ===== hw/rtl/bbls_ctrl.sv =====
`timescale 1ns / 1ps
`include "bouncing_ball_led_span_macros.svh"

module bbls_ctrl import bbls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_POS,
    S_UPD_POS,
    S_MUL_VEL,
    S_UPD_VEL,
    S_CHECK,
    S_BOUNCE,
    S_DIVIDE,
    S_EMIT,
    S_STATUS
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_dt = 1'b1;
          if (in_kind == KIND_LAUNCH) begin
            cmd.launch = 1'b1;
            state_nxt  = S_STATUS;
          end else if (sts.finished) begin
            state_nxt = S_STATUS;
          end else begin
            state_nxt = S_MUL_POS;
          end
        end
      end
      S_MUL_POS: begin
        cmd.mul_pos = 1'b1;
        state_nxt   = S_UPD_POS;
      end
      S_UPD_POS: begin
        cmd.upd_pos = 1'b1;
        state_nxt   = S_MUL_VEL;
      end
      S_MUL_VEL: begin
        cmd.mul_vel = 1'b1;
        state_nxt   = S_UPD_VEL;
      end
      S_UPD_VEL: begin
        cmd.upd_vel = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_BOUNCE;
      end
      S_BOUNCE: begin
        cmd.bounce = 1'b1;
        state_nxt  = sts.same_idx ? S_STATUS : S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_light = 1'b1;
          if (sts.span_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BBLS_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)
  `BBLS_ASSERT_IMP(a_emit_has_room, clk, rst_n, cmd.emit_light || cmd.emit_status, sts.out_free)
  `BBLS_ASSERT_NXT(a_divide_to_emit, clk, rst_n, (state_r == S_DIVIDE) && sts.div_done, state_r == S_EMIT)

endmodule

// ===== hw/rtl/bouncing_ball_led_span.sv =====
`timescale 1ns / 1ps

// Bouncing ball on an LED strip. A launch word loads the ball from the configuration
// registers and returns one status word; a tick word moves the ball by elapsed_time,
// bounces it at the strip end, and returns one light word per LED index passed over
// (at most MAX_SPAN, lowest first, last set on the final one) or one status word when
// the index is unchanged or the ball has finished. A launch or a tick of a finished
// ball goes straight to the status word. Any other tick passes S_MUL_POS, S_UPD_POS,
// S_MUL_VEL, S_UPD_VEL, S_CHECK and S_BOUNCE, with products from the shared 24x17
// multiplier (position, velocity, bounce product), then either the status word or the
// radix-2 fade-time divider and one light per cycle while the output is taken. The next
// word is taken once the last result sits in the output register. No clearing pass
// after reset.
module bouncing_ball_led_span import bbls_pkg::*; #(
  parameter int LED_COUNT = 1024,
  parameter int MAX_SPAN = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bbls_in_if.sink              in_ch,
  bbls_out_if.source           out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  bbls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbls_datapath #(
    .LED_COUNT (LED_COUNT),
    .MAX_SPAN  (MAX_SPAN)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_elapsed_time (in_ch.elapsed_time),
    .cmd             (cmd),
    .sts             (sts),
    .out_ch          (out_ch)
  );

endmodule
